### sv/smko_pkg.sv
`timescale 1ns / 1ps

package smko_pkg;

	localparam int MAX_ROWS = 64;
	localparam int KEY_COLS = 4;
	localparam int KEY_W    = 32;
	localparam int IDX_W    = $clog2(MAX_ROWS);
	localparam int CNT_W    = 7;
	localparam int KC_W     = 3;

	localparam logic [KEY_W-1:0] MISSING_KEY = 32'h8000_0000;

	// register indexes on paddr[3:2]
	localparam logic [1:0] REG_KEY_COUNT    = 2'd0;
	localparam logic [1:0] REG_DESC_MASK    = 2'd1;
	localparam logic [1:0] REG_MISSING_LAST = 2'd2;

	typedef logic [KEY_COLS-1:0][KEY_W-1:0] row_keys_t;

	typedef enum logic [1:0] {
		CMP_LT,
		CMP_EQ,
		CMP_GT
	} cmp_t;

	// Lexicographic compare of two key tuples; first differing active column decides.
	function automatic cmp_t cmp_rows(input row_keys_t x, input row_keys_t y,
			input logic [KC_W-1:0] kc, input logic [KEY_COLS-1:0] desc, input logic mlast);
		cmp_t            res;
		logic [KC_W-1:0] act;
		logic            done;
		logic            lt;
		res  = CMP_EQ;
		done = 1'b0;
		lt   = 1'b0;
		if (kc == '0) begin
			act = KC_W'(1);
		end else if (kc > KC_W'(KEY_COLS)) begin
			act = KC_W'(KEY_COLS);
		end else begin
			act = kc;
		end
		for (int c = 0; c < KEY_COLS; c++) begin
			if (!done && (KC_W'(c) < act) && (x[c] != y[c])) begin
				done = 1'b1;
				if (x[c] == MISSING_KEY) begin
					res = mlast ? CMP_GT : CMP_LT;
				end else if (y[c] == MISSING_KEY) begin
					res = mlast ? CMP_LT : CMP_GT;
				end else begin
					lt = $signed(x[c]) < $signed(y[c]);
					if (desc[c]) begin
						lt = !lt;
					end
					res = lt ? CMP_LT : CMP_GT;
				end
			end
		end
		return res;
	endfunction

endpackage

### sv/stable_multi_key_order_with_groups.sv
`timescale 1ns / 1ps

// Channel   Handshake            Payload
// row       row_valid/row_stall  key_a..key_d, final_row
// res       res_valid/res_stall  row_number, group_end, group_count, largest_group,
//                                dropped_rows, last_result
// cfg       APB (psel/penable)   paddr, pwdata, prdata, pready
//
// Rows load at one per cycle until the final row; row_stall then stays high.
// Rank pass: one compare per cycle through the single comparator, fed by the one read
// port of the key memory. Group pass: compares consecutive sorted rows.
// Emit: each result is read, then registered; res_stall holds the output register.
// arst_n resets control state and configuration to defaults; memories are not cleared.

module stable_multi_key_order_with_groups (
	input  logic                              clk,
	input  logic                              arst_n,
	// row channel
	input  logic                              row_valid,
	output logic                              row_stall,
	input  logic signed [smko_pkg::KEY_W-1:0] key_a,
	input  logic signed [smko_pkg::KEY_W-1:0] key_b,
	input  logic signed [smko_pkg::KEY_W-1:0] key_c,
	input  logic signed [smko_pkg::KEY_W-1:0] key_d,
	input  logic                              final_row,
	// result channel
	output logic                              res_valid,
	input  logic                              res_stall,
	output logic [smko_pkg::CNT_W-1:0]        row_number,
	output logic                              group_end,
	output logic [smko_pkg::CNT_W-1:0]        group_count,
	output logic [smko_pkg::CNT_W-1:0]        largest_group,
	output logic                              dropped_rows,
	output logic                              last_result,
	// configuration
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [3:0]                        paddr,
	input  logic [31:0]                       pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready
);

	localparam int IDX_W = smko_pkg::IDX_W;
	localparam int CNT_W = smko_pkg::CNT_W;

	typedef enum logic [3:0] {
		S_LOAD,
		S_RK_LDI,
		S_RK_GETI,
		S_RK_RUN,
		S_GP_START,
		S_GP_IDX,
		S_GP_KEY,
		S_GP_LAST,
		S_EM_RD,
		S_EM_OUT
	} state_t;

	state_t                          state_q;

	// configuration
	logic [smko_pkg::KC_W-1:0]       key_count_q;
	logic [smko_pkg::KEY_COLS-1:0]   desc_mask_q;
	logic                            missing_last_q;

	logic [CNT_W-1:0]                rows_held_q;
	logic                            overflow_q;
	logic [CNT_W-1:0]                i_q;
	logic [CNT_W-1:0]                k_q;
	logic [IDX_W-1:0]                k_s1;
	logic [IDX_W-1:0]                rank_q;
	logic [CNT_W-1:0]                p_q;
	logic [IDX_W-1:0]                idx_q;
	logic [IDX_W-1:0]                prev_idx_q;
	smko_pkg::row_keys_t             key_i_q;
	smko_pkg::row_keys_t             prev_keys_q;
	logic [CNT_W-1:0]                run_q;
	logic [CNT_W-1:0]                groups_q;
	logic [CNT_W-1:0]                largest_q;

	// output register
	logic                            res_valid_q;
	logic [CNT_W-1:0]                row_number_q;
	logic                            group_end_q;
	logic [CNT_W-1:0]                group_count_q;
	logic [CNT_W-1:0]                largest_group_q;
	logic                            dropped_rows_q;
	logic                            last_result_q;

	// memories: one key tuple per row, and the sorted order {group end, row index}
	smko_pkg::row_keys_t             key_mem [smko_pkg::MAX_ROWS];
	smko_pkg::row_keys_t             key_rd_q;
	logic [IDX_W-1:0]                key_raddr;
	logic                            key_we;

	logic [IDX_W:0]                  order_mem [smko_pkg::MAX_ROWS];
	logic [IDX_W:0]                  order_rd_q;
	logic [IDX_W-1:0]                order_raddr;
	logic                            order_we;
	logic [IDX_W-1:0]                order_waddr;
	logic [IDX_W:0]                  order_wdata;

	logic                            row_accept;
	logic                            row_fits;
	logic                            out_free;
	logic                            cfg_we;
	smko_pkg::row_keys_t             op_a;
	smko_pkg::row_keys_t             op_b;
	smko_pkg::cmp_t                  cmp_res;
	logic                            hit;
	logic                            diff;
	logic [IDX_W-1:0]                rank_nxt;
	logic                            emit_last;

	assign row_stall  = (state_q != S_LOAD);
	assign row_accept = row_valid && !row_stall;
	assign row_fits   = (rows_held_q != CNT_W'(smko_pkg::MAX_ROWS));
	assign out_free   = !res_valid_q || !res_stall;
	assign cfg_we     = psel && penable && pwrite;
	assign pready     = 1'b1;

	always_comb begin
		case (paddr[3:2])
			smko_pkg::REG_KEY_COUNT:    prdata = {29'd0, key_count_q};
			smko_pkg::REG_DESC_MASK:    prdata = {28'd0, desc_mask_q};
			smko_pkg::REG_MISSING_LAST: prdata = {31'd0, missing_last_q};
			default:                    prdata = 32'd0;
		endcase
	end

	// the one shared comparator: rank pass compares row k against row i,
	// group pass compares consecutive sorted rows
	assign op_a    = (state_q == S_RK_RUN) ? key_rd_q : prev_keys_q;
	assign op_b    = (state_q == S_RK_RUN) ? key_i_q  : key_rd_q;
	assign cmp_res = smko_pkg::cmp_rows(op_a, op_b, key_count_q, desc_mask_q, missing_last_q);

	// row k lands before row i: strictly less, or equal and earlier in input order
	assign hit       = (cmp_res == smko_pkg::CMP_LT) ||
		((cmp_res == smko_pkg::CMP_EQ) && ({1'b0, k_s1} < i_q));
	assign diff      = (cmp_res != smko_pkg::CMP_EQ);
	assign rank_nxt  = rank_q + {{(IDX_W-1){1'b0}}, hit};
	assign emit_last = ((p_q + CNT_W'(1)) == rows_held_q);

	assign key_we = row_accept && row_fits;

	always_comb begin
		case (state_q)
			S_RK_LDI: key_raddr = i_q[IDX_W-1:0];
			S_RK_RUN: key_raddr = k_q[IDX_W-1:0];
			S_GP_IDX: key_raddr = order_rd_q[IDX_W-1:0];
			default:  key_raddr = '0;
		endcase
	end

	always_comb begin
		case (state_q)
			S_GP_KEY: order_raddr = IDX_W'(p_q + CNT_W'(1));
			S_EM_RD:  order_raddr = p_q[IDX_W-1:0];
			S_EM_OUT: order_raddr = p_q[IDX_W-1:0];
			default:  order_raddr = '0;
		endcase
	end

	always_comb begin
		order_we    = 1'b0;
		order_waddr = '0;
		order_wdata = '0;
		case (state_q)
			S_RK_RUN: begin
				order_we    = (k_q == rows_held_q);
				order_waddr = rank_nxt;
				order_wdata = {1'b0, i_q[IDX_W-1:0]};
			end
			S_GP_KEY: begin
				order_we    = (p_q != '0);
				order_waddr = IDX_W'(p_q - CNT_W'(1));
				order_wdata = {diff, prev_idx_q};
			end
			S_GP_LAST: begin
				order_we    = 1'b1;
				order_waddr = IDX_W'(rows_held_q - CNT_W'(1));
				order_wdata = {1'b1, prev_idx_q};
			end
			default: begin
				order_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (key_we) begin
			key_mem[rows_held_q[IDX_W-1:0]] <= {key_d, key_c, key_b, key_a};
		end
		key_rd_q <= key_mem[key_raddr];
	end

	always_ff @(posedge clk) begin
		if (order_we) begin
			order_mem[order_waddr] <= order_wdata;
		end
		order_rd_q <= order_mem[order_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_LOAD;
			key_count_q     <= smko_pkg::KC_W'(1);
			desc_mask_q     <= '0;
			missing_last_q  <= 1'b1;
			rows_held_q     <= '0;
			overflow_q      <= 1'b0;
			i_q             <= '0;
			k_q             <= '0;
			k_s1            <= '0;
			rank_q          <= '0;
			p_q             <= '0;
			idx_q           <= '0;
			prev_idx_q      <= '0;
			key_i_q         <= '0;
			prev_keys_q     <= '0;
			run_q           <= '0;
			groups_q        <= '0;
			largest_q       <= '0;
			res_valid_q     <= 1'b0;
			row_number_q    <= '0;
			group_end_q     <= 1'b0;
			group_count_q   <= '0;
			largest_group_q <= '0;
			dropped_rows_q  <= 1'b0;
			last_result_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (paddr[3:2])
					smko_pkg::REG_KEY_COUNT:    key_count_q    <= pwdata[smko_pkg::KC_W-1:0];
					smko_pkg::REG_DESC_MASK:    desc_mask_q    <= pwdata[smko_pkg::KEY_COLS-1:0];
					smko_pkg::REG_MISSING_LAST: missing_last_q <= pwdata[0];
					default:                    ;
				endcase
			end

			// in S_EM_OUT the output register is reloaded below instead
			if (res_valid_q && !res_stall && (state_q != S_EM_OUT)) begin
				res_valid_q <= 1'b0;
			end

			case (state_q)
				S_LOAD: begin
					if (row_accept) begin
						if (row_fits) begin
							rows_held_q <= rows_held_q + CNT_W'(1);
						end else begin
							overflow_q <= 1'b1;
						end
						if (final_row) begin
							i_q     <= '0;
							state_q <= S_RK_LDI;
						end
					end
				end
				S_RK_LDI: begin
					state_q <= S_RK_GETI;
				end
				S_RK_GETI: begin
					// key_raddr is zero here, so row 0 arrives next cycle
					key_i_q <= key_rd_q;
					k_s1    <= '0;
					k_q     <= CNT_W'(1);
					rank_q  <= '0;
					state_q <= S_RK_RUN;
				end
				S_RK_RUN: begin
					if (k_q != rows_held_q) begin
						rank_q <= rank_nxt;
						k_s1   <= k_q[IDX_W-1:0];
						k_q    <= k_q + CNT_W'(1);
					end else begin
						i_q <= i_q + CNT_W'(1);
						if ((i_q + CNT_W'(1)) == rows_held_q) begin
							state_q <= S_GP_START;
						end else begin
							state_q <= S_RK_LDI;
						end
					end
				end
				S_GP_START: begin
					p_q       <= '0;
					groups_q  <= '0;
					largest_q <= '0;
					run_q     <= '0;
					state_q   <= S_GP_IDX;
				end
				S_GP_IDX: begin
					idx_q   <= order_rd_q[IDX_W-1:0];
					state_q <= S_GP_KEY;
				end
				S_GP_KEY: begin
					prev_keys_q <= key_rd_q;
					prev_idx_q  <= idx_q;
					if (p_q == '0) begin
						run_q <= CNT_W'(1);
					end else if (diff) begin
						groups_q  <= groups_q + CNT_W'(1);
						largest_q <= (run_q > largest_q) ? run_q : largest_q;
						run_q     <= CNT_W'(1);
					end else begin
						run_q <= run_q + CNT_W'(1);
					end
					p_q <= p_q + CNT_W'(1);
					if ((p_q + CNT_W'(1)) == rows_held_q) begin
						state_q <= S_GP_LAST;
					end else begin
						state_q <= S_GP_IDX;
					end
				end
				S_GP_LAST: begin
					groups_q  <= groups_q + CNT_W'(1);
					largest_q <= (run_q > largest_q) ? run_q : largest_q;
					p_q       <= '0;
					state_q   <= S_EM_RD;
				end
				S_EM_RD: begin
					state_q <= S_EM_OUT;
				end
				S_EM_OUT: begin
					if (out_free) begin
						res_valid_q     <= 1'b1;
						row_number_q    <= CNT_W'(order_rd_q[IDX_W-1:0]) + CNT_W'(1);
						group_end_q     <= order_rd_q[IDX_W];
						group_count_q   <= emit_last ? groups_q : '0;
						largest_group_q <= emit_last ? largest_q : '0;
						dropped_rows_q  <= overflow_q;
						last_result_q   <= emit_last;
						p_q             <= p_q + CNT_W'(1);
						if (emit_last) begin
							rows_held_q <= '0;
							overflow_q  <= 1'b0;
							state_q     <= S_LOAD;
						end else begin
							state_q <= S_EM_RD;
						end
					end
				end
				default: begin
					state_q <= S_LOAD;
				end
			endcase
		end
	end

	assign res_valid     = res_valid_q;
	assign row_number    = row_number_q;
	assign group_end     = group_end_q;
	assign group_count   = group_count_q;
	assign largest_group = largest_group_q;
	assign dropped_rows  = dropped_rows_q;
	assign last_result   = last_result_q;

	a_rows_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		rows_held_q <= CNT_W'(smko_pkg::MAX_ROWS))
		else $error("row count above capacity");

	a_rank_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RK_RUN) |-> ({1'b0, rank_q} < rows_held_q))
		else $error("rank beyond held rows");

	a_last_summary: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && last_result) |-> (group_count != '0 && largest_group != '0 &&
			group_end))
		else $error("final result without group summary");

	a_mid_summary: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !last_result) |-> (group_count == '0 && largest_group == '0))
		else $error("summary on a non-final result");

	a_end_to_load: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EM_OUT && out_free && emit_last) |=>
			(state_q == S_LOAD && rows_held_q == '0 && !overflow_q))
		else $error("set not cleared after last result");

endmodule
